/* design/symbol_rle_encoder_macros.svh */
// assertion macros used by the symbol run-length encoder checker
`ifndef SYMBOL_RLE_ENCODER_MACROS_SVH
`define SYMBOL_RLE_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/srle_pkg.sv */
// types and constants of the symbol run-length encoder
package srle_pkg;

    localparam int ADDR_WIDTH       = 24;
    localparam int MAX_SYMBOL_BYTES = 4;
    localparam int SYMBOL_WIDTH     = 8 * MAX_SYMBOL_BYTES;
    localparam int BYTES_WIDTH      = 3;
    localparam int CFG_DATA_WIDTH   = 24;
    localparam int MAX_RESULTS      = 4;
    localparam int DEST_WIDTH       = ADDR_WIDTH + 2;

    localparam logic CFG_SYMBOL_BYTES = 1'b0;
    localparam logic CFG_CAPACITY     = 1'b1;

    localparam logic [7:0] RUN_BIAS   = 8'd126;
    localparam logic [7:0] RUN_MAX    = 8'd129;
    localparam logic [7:0] LIT_MAX    = 8'd128;
    localparam logic [7:0] LIT_FULL_HDR = 8'd127;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0]   addr;
        logic [SYMBOL_WIDTH-1:0] data;
        logic [BYTES_WIDTH-1:0]  bytes;
        logic                    is_header;
        logic                    overflow;
    } result_t;

endpackage

/* design/symbol_rle_encoder.sv */
// symbol run-length encoder: packbits-style coder with byte-addressed writes
//
// input channel s_*: one symbol per transaction, s_last_symbol closes a stream.
// result channel m_*: write transactions; headers land in slots reserved
// before their packets, symbol copies are written in place.
// configuration: cfg_write with cfg_index 0 sets symbol_bytes, index 1 sets
// capacity; write only while the block is idle.
// each symbol is coded combinationally: one compare, one small product and a few adds
// between the stream state registers and a four-entry result buffer.
// results of a transaction appear from the next cycle; while m_ready is high
// they leave one per cycle, and a transaction causing zero or one result lets
// the next symbol in every cycle, one causing k results holds s_ready low
// while its first k-1 drain. a stalled m_ready holds the current result and
// keeps s_ready low until the last result of the transaction is taken.
// reset clears the stream state and sets symbol_bytes to 1 and capacity to
// its maximum; after stream_done the stream state clears, registers stay.
module symbol_rle_encoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [srle_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [srle_pkg::SYMBOL_WIDTH-1:0]   s_symbol,
    input  logic                                s_last_symbol,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [srle_pkg::ADDR_WIDTH-1:0]     m_write_addr,
    output logic [srle_pkg::SYMBOL_WIDTH-1:0]   m_write_data,
    output logic [srle_pkg::BYTES_WIDTH-1:0]    m_write_bytes,
    output logic                                m_is_header,
    output logic                                m_item_done,
    output logic                                m_stream_done,
    output logic [srle_pkg::ADDR_WIDTH-1:0]     m_coded_length,
    output logic                                m_overflow
);

    localparam int DW = srle_pkg::DEST_WIDTH;
    localparam int AW = srle_pkg::ADDR_WIDTH;
    localparam int SW = srle_pkg::SYMBOL_WIDTH;
    localparam int BW = srle_pkg::BYTES_WIDTH;

    // configuration
    logic [BW-1:0] symbol_bytes_reg;
    logic [AW-1:0] capacity_reg;

    // stream state
    logic [SW-1:0] prev_symbol_reg, prev_symbol_next;
    logic          have_prev_reg, have_prev_next;
    logic [7:0]    run_count_reg, run_count_next;
    logic [7:0]    literal_count_reg, literal_count_next;
    logic [AW-1:0] write_pointer_reg, write_pointer_next;
    logic          aborted_reg, aborted_next;

    // result buffer
    srle_pkg::result_t res_buf_reg [srle_pkg::MAX_RESULTS];
    logic [2:0]        res_cnt_reg;
    logic [1:0]        rd_ptr_reg;
    logic              out_valid_reg;
    logic              done_reg;
    logic [AW-1:0]     coded_len_reg;

    srle_pkg::result_t res_c [srle_pkg::MAX_RESULTS];
    logic [2:0]        res_cnt_c;
    logic              done_c;
    logic [AW-1:0]     coded_len_c;

    logic [BW-1:0] sb;
    logic [SW-1:0] sym_mask;
    logic          sym_equal;
    logic          in_fire;
    logic          last_out;

    function automatic srle_pkg::result_t mk_result(
        input logic [DW-1:0] addr,
        input logic [SW-1:0] data,
        input logic [BW-1:0] bytes,
        input logic          hdr,
        input logic          ovf
    );
        srle_pkg::result_t r;
        r.addr      = addr[AW-1:0];
        r.data      = data;
        r.bytes     = bytes;
        r.is_header = hdr;
        r.overflow  = ovf;
        return r;
    endfunction

    // symbol size clamp and byte mask
    always_comb begin
        if (symbol_bytes_reg == '0) begin
            sb = BW'(1);
        end else if (symbol_bytes_reg > BW'(srle_pkg::MAX_SYMBOL_BYTES)) begin
            sb = BW'(srle_pkg::MAX_SYMBOL_BYTES);
        end else begin
            sb = symbol_bytes_reg;
        end
        for (int i = 0; i < srle_pkg::MAX_SYMBOL_BYTES; i++) begin
            sym_mask[8*i +: 8] = (BW'(i) < sb) ? 8'hFF : 8'h00;
        end
    end

    assign sym_equal = ((prev_symbol_reg ^ s_symbol) & sym_mask) == '0;

    // one pass over the current symbol
    always_comb begin
        logic [DW-1:0] dest;
        logic [DW-1:0] off;
        logic [DW-1:0] sb_ext;
        logic [DW-1:0] cap_ext;
        logic [7:0]    run;
        logic [7:0]    lit;
        logic          ovf;
        logic [SW-1:0] hdr_run;

        for (int i = 0; i < srle_pkg::MAX_RESULTS; i++) begin
            res_c[i] = '0;
        end
        res_cnt_c   = 3'd0;
        done_c      = 1'b0;
        coded_len_c = '0;

        prev_symbol_next   = prev_symbol_reg;
        have_prev_next     = have_prev_reg;
        run_count_next     = run_count_reg;
        literal_count_next = literal_count_reg;
        write_pointer_next = write_pointer_reg;
        aborted_next       = aborted_reg;

        dest    = DW'(write_pointer_reg);
        sb_ext  = DW'(sb);
        cap_ext = DW'(capacity_reg);
        off     = DW'(literal_count_reg) * sb_ext;
        run     = run_count_reg;
        lit     = literal_count_reg;
        ovf     = 1'b0;
        hdr_run = '0;

        if (aborted_reg) begin
            if (s_last_symbol) begin
                res_c[0]           = mk_result('0, '0, '0, 1'b0, 1'b1);
                res_cnt_c          = 3'd1;
                done_c             = 1'b1;
                prev_symbol_next   = '0;
                have_prev_next     = 1'b0;
                run_count_next     = 8'd1;
                literal_count_next = 8'd0;
                write_pointer_next = '0;
                aborted_next       = 1'b0;
            end
        end else begin
            if (have_prev_reg) begin
                if (sym_equal) begin
                    if (run == srle_pkg::RUN_MAX) begin
                        res_c[res_cnt_c[1:0]] = mk_result(dest,
                            SW'(srle_pkg::RUN_BIAS + srle_pkg::RUN_MAX), BW'(1), 1'b1, 1'b0);
                        res_cnt_c = res_cnt_c + 3'd1;
                        dest      = dest + sb_ext + DW'(1);
                        run       = 8'd1;
                    end else begin
                        run = run + 8'd1;
                        if (lit != 8'd0) begin
                            res_c[res_cnt_c[1:0]] = mk_result(dest, SW'(lit - 8'd1),
                                BW'(1), 1'b1, 1'b0);
                            res_cnt_c = res_cnt_c + 3'd1;
                            dest      = dest + DW'(1) + off;
                            lit       = 8'd0;
                            off       = '0;
                        end
                        if (run == 8'd2) begin
                            if (dest + DW'(1) + sb_ext > cap_ext) begin
                                ovf = 1'b1;
                            end else begin
                                res_c[res_cnt_c[1:0]] = mk_result(dest + DW'(1),
                                    prev_symbol_reg & sym_mask, sb, 1'b0, 1'b0);
                                res_cnt_c = res_cnt_c + 3'd1;
                            end
                        end
                    end
                end else begin
                    if (run > 8'd1) begin
                        hdr_run = SW'(srle_pkg::RUN_BIAS + run);
                        res_c[res_cnt_c[1:0]] = mk_result(dest, hdr_run, BW'(1), 1'b1, 1'b0);
                        res_cnt_c = res_cnt_c + 3'd1;
                        dest      = dest + sb_ext + DW'(1);
                        run       = 8'd1;
                    end else if (dest + DW'(1) + off + sb_ext > cap_ext) begin
                        ovf = 1'b1;
                    end else begin
                        res_c[res_cnt_c[1:0]] = mk_result(dest + DW'(1) + off,
                            prev_symbol_reg & sym_mask, sb, 1'b0, 1'b0);
                        res_cnt_c = res_cnt_c + 3'd1;
                        lit       = lit + 8'd1;
                        off       = off + sb_ext;
                        if (lit == srle_pkg::LIT_MAX) begin
                            res_c[res_cnt_c[1:0]] = mk_result(dest,
                                SW'(srle_pkg::LIT_FULL_HDR), BW'(1), 1'b1, 1'b0);
                            res_cnt_c = res_cnt_c + 3'd1;
                            dest      = dest + DW'(1) + off;
                            lit       = 8'd0;
                            off       = '0;
                        end
                    end
                end
            end

            if (!ovf && s_last_symbol) begin
                if (run > 8'd1) begin
                    hdr_run = SW'(srle_pkg::RUN_BIAS + run);
                    res_c[res_cnt_c[1:0]] = mk_result(dest, hdr_run, BW'(1), 1'b1, 1'b0);
                    res_cnt_c = res_cnt_c + 3'd1;
                    dest      = dest + sb_ext + DW'(1);
                end else if (dest + DW'(1) + off + sb_ext > cap_ext) begin
                    ovf = 1'b1;
                end else begin
                    res_c[res_cnt_c[1:0]] = mk_result(dest + DW'(1) + off,
                        s_symbol & sym_mask, sb, 1'b0, 1'b0);
                    res_cnt_c = res_cnt_c + 3'd1;
                    off       = off + sb_ext;
                    res_c[res_cnt_c[1:0]] = mk_result(dest, SW'(lit), BW'(1), 1'b1, 1'b0);
                    res_cnt_c = res_cnt_c + 3'd1;
                    dest      = dest + DW'(1) + off;
                end
            end

            if (ovf || s_last_symbol) begin
                if (ovf) begin
                    res_c[res_cnt_c[1:0]] = mk_result('0, '0, '0, 1'b0, 1'b1);
                    res_cnt_c = res_cnt_c + 3'd1;
                end else begin
                    coded_len_c = dest[AW-1:0];
                end
                done_c             = s_last_symbol;
                prev_symbol_next   = '0;
                have_prev_next     = 1'b0;
                run_count_next     = 8'd1;
                literal_count_next = 8'd0;
                write_pointer_next = '0;
                aborted_next       = !s_last_symbol;
            end else begin
                prev_symbol_next   = s_symbol;
                have_prev_next     = 1'b1;
                run_count_next     = run;
                literal_count_next = lit;
                write_pointer_next = dest[AW-1:0];
            end
        end
    end

    // result channel
    assign last_out = ({1'b0, rd_ptr_reg} == res_cnt_reg - 3'd1);
    assign s_ready  = !out_valid_reg || (m_ready && last_out);
    assign in_fire  = s_valid && s_ready;

    assign m_valid        = out_valid_reg;
    assign m_write_addr   = res_buf_reg[rd_ptr_reg].addr;
    assign m_write_data   = res_buf_reg[rd_ptr_reg].data;
    assign m_write_bytes  = res_buf_reg[rd_ptr_reg].bytes;
    assign m_is_header    = res_buf_reg[rd_ptr_reg].is_header;
    assign m_overflow     = res_buf_reg[rd_ptr_reg].overflow;
    assign m_item_done    = last_out;
    assign m_stream_done  = done_reg && last_out;
    assign m_coded_length = (done_reg && last_out) ? coded_len_reg : '0;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_bytes_reg <= BW'(1);
            capacity_reg     <= '1;
        end else if (cfg_write) begin
            unique case (cfg_index)
                srle_pkg::CFG_SYMBOL_BYTES: symbol_bytes_reg <= cfg_data[BW-1:0];
                srle_pkg::CFG_CAPACITY:     capacity_reg     <= cfg_data[AW-1:0];
            endcase
        end
    end

    // stream state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_symbol_reg   <= '0;
            have_prev_reg     <= 1'b0;
            run_count_reg     <= 8'd1;
            literal_count_reg <= 8'd0;
            write_pointer_reg <= '0;
            aborted_reg       <= 1'b0;
        end else if (in_fire) begin
            prev_symbol_reg   <= prev_symbol_next;
            have_prev_reg     <= have_prev_next;
            run_count_reg     <= run_count_next;
            literal_count_reg <= literal_count_next;
            write_pointer_reg <= write_pointer_next;
            aborted_reg       <= aborted_next;
        end
    end

    // result buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            res_cnt_reg   <= 3'd1;
            rd_ptr_reg    <= 2'd0;
        end else if (in_fire) begin
            out_valid_reg <= (res_cnt_c != 3'd0);
            res_cnt_reg   <= res_cnt_c;
            rd_ptr_reg    <= 2'd0;
        end else if (out_valid_reg && m_ready) begin
            if (last_out) begin
                out_valid_reg <= 1'b0;
            end else begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int i = 0; i < srle_pkg::MAX_RESULTS; i++) begin
                res_buf_reg[i] <= res_c[i];
            end
            done_reg      <= done_c;
            coded_len_reg <= coded_len_c;
        end
    end

endmodule

/* design/srle_checker.sv */
// port-level checker for the symbol run-length encoder, bound to the top level
`include "symbol_rle_encoder_macros.svh"

module srle_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [srle_pkg::ADDR_WIDTH-1:0]     m_write_addr,
    input logic [srle_pkg::SYMBOL_WIDTH-1:0]   m_write_data,
    input logic [srle_pkg::BYTES_WIDTH-1:0]    m_write_bytes,
    input logic                                m_is_header,
    input logic                                m_item_done,
    input logic                                m_stream_done,
    input logic [srle_pkg::ADDR_WIDTH-1:0]     m_coded_length,
    input logic                                m_overflow
);

    // stalled result transaction holds
    `SRLE_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_write_addr) && $stable(m_write_data)
        && $stable(m_write_bytes) && $stable(m_is_header) && $stable(m_item_done)
        && $stable(m_stream_done) && $stable(m_overflow),
        "result changed while stalled")

    // stream end is always the last result of its symbol
    `SRLE_ASSERT_NOW(a_done_is_last, aclk, aresetn, m_valid && m_stream_done,
        m_item_done, "stream_done without item_done")

    // overflow reports carry no write and no length
    `SRLE_ASSERT_NOW(a_ovf_empty, aclk, aresetn, m_valid && m_overflow,
        (m_write_bytes == '0) && !m_is_header && (m_write_addr == '0)
        && (m_coded_length == '0), "overflow result carries a write")

    // a header is a single byte and never an overflow
    `SRLE_ASSERT_NOW(a_hdr_one_byte, aclk, aresetn, m_valid && m_is_header,
        (m_write_bytes == 3'd1) && !m_overflow, "header write not one byte")

endmodule

bind symbol_rle_encoder srle_checker u_srle_checker (.*);

/* dv/symbol_rle_encoder_tb.sv */
// testbench of the symbol run-length encoder: directed table, random streams, predictor checking
`timescale 1ns / 1ps

module symbol_rle_encoder_tb;

    typedef struct packed {
        logic [srle_pkg::ADDR_WIDTH-1:0]   addr;
        logic [srle_pkg::SYMBOL_WIDTH-1:0] data;
        logic [srle_pkg::BYTES_WIDTH-1:0]  nbytes;
        logic                              hdr;
        logic                              item_end;
        logic                              strm_end;
        logic [srle_pkg::ADDR_WIDTH-1:0]   length;
        logic                              ovf;
    } coded_write_t;

    typedef enum logic {ROW_SYMBOL, ROW_CONFIG} row_kind_t;

    // n_writes < 0: row is checked by the predictor only
    typedef struct packed {
        row_kind_t    kind;
        logic         reg_index;
        logic [31:0]  value;
        logic         last;
        int           n_writes;
        coded_write_t fin;
    } stim_row_t;

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                cfg_write;
    logic                                cfg_index;
    logic [srle_pkg::CFG_DATA_WIDTH-1:0] cfg_data;
    logic                                s_valid;
    logic                                s_ready;
    logic [srle_pkg::SYMBOL_WIDTH-1:0]   s_symbol;
    logic                                s_last_symbol;
    logic                                m_valid;
    logic                                m_ready;
    logic [srle_pkg::ADDR_WIDTH-1:0]     m_write_addr;
    logic [srle_pkg::SYMBOL_WIDTH-1:0]   m_write_data;
    logic [srle_pkg::BYTES_WIDTH-1:0]    m_write_bytes;
    logic                                m_is_header;
    logic                                m_item_done;
    logic                                m_stream_done;
    logic [srle_pkg::ADDR_WIDTH-1:0]     m_coded_length;
    logic                                m_overflow;

    // encoder model state
    logic [srle_pkg::BYTES_WIDTH-1:0] cfg_sym_bytes;
    logic [srle_pkg::ADDR_WIDTH-1:0]  cfg_capacity;
    logic [31:0]                      prev_sym;
    bit                               have_prev;
    int unsigned                      run_len;
    int unsigned                      lit_len;
    int unsigned                      wr_ptr;
    bit                               stream_aborted;

    coded_write_t step_writes[$];
    coded_write_t pending_writes[$];
    stim_row_t    directed_rows[$];

    int           known_n;
    coded_write_t known_w;
    int           sent_items = 0;
    int           mismatches = 0;

    symbol_rle_encoder u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_symbol       (s_symbol),
        .s_last_symbol  (s_last_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_addr   (m_write_addr),
        .m_write_data   (m_write_data),
        .m_write_bytes  (m_write_bytes),
        .m_is_header    (m_is_header),
        .m_item_done    (m_item_done),
        .m_stream_done  (m_stream_done),
        .m_coded_length (m_coded_length),
        .m_overflow     (m_overflow)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned eff_bytes(input logic [srle_pkg::BYTES_WIDTH-1:0] raw);
        if (raw < 1) return 1;
        if (raw > srle_pkg::MAX_SYMBOL_BYTES) return srle_pkg::MAX_SYMBOL_BYTES;
        return raw;
    endfunction

    function automatic logic [31:0] byte_mask(input int unsigned sb);
        if (sb >= srle_pkg::MAX_SYMBOL_BYTES) return 32'hFFFF_FFFF;
        return (32'h1 << (8 * sb)) - 32'h1;
    endfunction

    function automatic coded_write_t mk_write(input int unsigned addr, input logic [31:0] data,
                                              input int unsigned nb, input bit hdr,
                                              input bit ovf);
        coded_write_t w;
        w        = '0;
        w.addr   = addr[srle_pkg::ADDR_WIDTH-1:0];
        w.data   = data;
        w.nbytes = nb[srle_pkg::BYTES_WIDTH-1:0];
        w.hdr    = hdr;
        w.ovf    = ovf;
        return w;
    endfunction

    function automatic coded_write_t fin_w(input int unsigned addr, input logic [31:0] data,
                                           input int unsigned nb, input bit hdr, input bit strm,
                                           input int unsigned len, input bit ovf);
        coded_write_t w;
        w          = mk_write(addr, data, nb, hdr, ovf);
        w.item_end = 1'b1;
        w.strm_end = strm;
        w.length   = len[srle_pkg::ADDR_WIDTH-1:0];
        return w;
    endfunction

    function automatic stim_row_t sym_row(input logic [31:0] sym, input bit last,
                                          input int n_writes = -1,
                                          input coded_write_t fin = '0);
        stim_row_t r;
        r          = '0;
        r.kind     = ROW_SYMBOL;
        r.value    = sym;
        r.last     = last;
        r.n_writes = n_writes;
        r.fin      = fin;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic idx, input logic [31:0] val);
        stim_row_t r;
        r           = '0;
        r.kind      = ROW_CONFIG;
        r.reg_index = idx;
        r.value     = val;
        r.n_writes  = -1;
        return r;
    endfunction

    function automatic void clear_stream();
        prev_sym       = '0;
        have_prev      = 1'b0;
        run_len        = 1;
        lit_len        = 0;
        wr_ptr         = 0;
        stream_aborted = 1'b0;
    endfunction

    // packs one symbol into step_writes and advances the stream state
    task automatic encode_symbol(input logic [31:0] sym, input bit last);
        int unsigned sb;
        int unsigned dest;
        int unsigned cap;
        logic [31:0] keep;
        bit          ovf;
        step_writes.delete();
        ovf = 1'b0;
        if (stream_aborted) begin
            if (last) begin
                step_writes.push_back(mk_write(0, 0, 0, 1'b0, 1'b1));
                step_writes[$].strm_end = 1'b1;
                clear_stream();
            end
        end else begin
            sb   = eff_bytes(cfg_sym_bytes);
            keep = byte_mask(sb);
            dest = wr_ptr;
            cap  = cfg_capacity;
            if (have_prev) begin
                if (((prev_sym ^ sym) & keep) == 0) begin
                    if (run_len == srle_pkg::RUN_MAX) begin
                        step_writes.push_back(mk_write(dest,
                            srle_pkg::RUN_BIAS + srle_pkg::RUN_MAX, 1, 1'b1, 1'b0));
                        dest    = dest + sb + 1;
                        run_len = 1;
                    end else begin
                        run_len++;
                        if (lit_len > 0) begin
                            step_writes.push_back(mk_write(dest, lit_len - 1, 1, 1'b1, 1'b0));
                            dest    = dest + 1 + sb * lit_len;
                            lit_len = 0;
                        end
                        if (run_len == 2) begin
                            if (dest + 1 + sb > cap)
                                ovf = 1'b1;
                            else
                                step_writes.push_back(mk_write(dest + 1, prev_sym & keep, sb,
                                                               1'b0, 1'b0));
                        end
                    end
                end else if (run_len > 1) begin
                    step_writes.push_back(mk_write(dest, srle_pkg::RUN_BIAS + run_len, 1,
                                                   1'b1, 1'b0));
                    dest    = dest + sb + 1;
                    run_len = 1;
                end else if (dest + 1 + lit_len * sb + sb > cap) begin
                    ovf = 1'b1;
                end else begin
                    step_writes.push_back(mk_write(dest + 1 + lit_len * sb, prev_sym & keep, sb,
                                                   1'b0, 1'b0));
                    lit_len++;
                    if (lit_len == srle_pkg::LIT_MAX) begin
                        step_writes.push_back(mk_write(dest, srle_pkg::LIT_FULL_HDR, 1,
                                                       1'b1, 1'b0));
                        dest    = dest + 1 + sb * srle_pkg::LIT_MAX;
                        lit_len = 0;
                    end
                end
            end
            if (!ovf && last) begin
                if (run_len > 1) begin
                    step_writes.push_back(mk_write(dest, srle_pkg::RUN_BIAS + run_len, 1,
                                                   1'b1, 1'b0));
                    dest = dest + sb + 1;
                end else if (dest + 1 + lit_len * sb + sb > cap) begin
                    ovf = 1'b1;
                end else begin
                    step_writes.push_back(mk_write(dest + 1 + lit_len * sb, sym & keep, sb,
                                                   1'b0, 1'b0));
                    lit_len++;
                    step_writes.push_back(mk_write(dest, lit_len - 1, 1, 1'b1, 1'b0));
                    dest = dest + 1 + sb * lit_len;
                end
            end
            if (ovf) begin
                step_writes.push_back(mk_write(0, 0, 0, 1'b0, 1'b1));
                clear_stream();
                if (last)
                    step_writes[$].strm_end = 1'b1;
                else
                    stream_aborted = 1'b1;
            end else if (last) begin
                step_writes[$].strm_end = 1'b1;
                step_writes[$].length   = dest[srle_pkg::ADDR_WIDTH-1:0];
                clear_stream();
            end else begin
                wr_ptr    = dest & ((32'h1 << srle_pkg::ADDR_WIDTH) - 32'h1);
                prev_sym  = sym;
                have_prev = 1'b1;
            end
        end
        if (step_writes.size() > 0)
            step_writes[$].item_end = 1'b1;
    endtask

    task automatic note_mismatch(input string tag, input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t %s %s: expected %0h, actual %0h", $time, tag, field, want, got);
        mismatches++;
    endtask

    task automatic compare_write(input string tag, input coded_write_t want,
                                 input coded_write_t got);
        if (got.addr !== want.addr) note_mismatch(tag, "write_addr", want.addr, got.addr);
        if (got.data !== want.data) note_mismatch(tag, "write_data", want.data, got.data);
        if (got.nbytes !== want.nbytes)
            note_mismatch(tag, "write_bytes", want.nbytes, got.nbytes);
        if (got.hdr !== want.hdr) note_mismatch(tag, "is_header", want.hdr, got.hdr);
        if (got.item_end !== want.item_end)
            note_mismatch(tag, "item_done", want.item_end, got.item_end);
        if (got.strm_end !== want.strm_end)
            note_mismatch(tag, "stream_done", want.strm_end, got.strm_end);
        if (got.length !== want.length)
            note_mismatch(tag, "coded_length", want.length, got.length);
        if (got.ovf !== want.ovf) note_mismatch(tag, "overflow", want.ovf, got.ovf);
    endtask

    always @(posedge aclk) begin
        coded_write_t got;
        coded_write_t want;
        if (!aresetn) begin
            cfg_sym_bytes = 3'd1;
            cfg_capacity  = 24'hFF_FFFF;
            clear_stream();
            pending_writes.delete();
        end else begin
            if (cfg_write) begin
                if (cfg_index == srle_pkg::CFG_SYMBOL_BYTES)
                    cfg_sym_bytes = cfg_data[srle_pkg::BYTES_WIDTH-1:0];
                else
                    cfg_capacity = cfg_data;
            end
            if (s_valid && s_ready) begin
                encode_symbol(s_symbol, s_last_symbol);
                if (known_n >= 0) begin
                    if (step_writes.size() != known_n) begin
                        $display("%0t table result count: expected %0d, actual %0d",
                                 $time, known_n, step_writes.size());
                        mismatches++;
                    end else if (known_n > 0) begin
                        compare_write("table", known_w, step_writes[$]);
                    end
                end
                foreach (step_writes[k]) pending_writes.push_back(step_writes[k]);
            end
            if (m_valid && m_ready) begin
                got = {m_write_addr, m_write_data, m_write_bytes, m_is_header, m_item_done,
                       m_stream_done, m_coded_length, m_overflow};
                if (pending_writes.size() == 0) begin
                    $display("%0t result: expected none, actual addr %0h data %0h bytes %0d",
                             $time, got.addr, got.data, got.nbytes);
                    mismatches++;
                end else begin
                    want = pending_writes.pop_front();
                    compare_write("result", want, got);
                end
            end
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic logic [31:0] next_symbol(input logic [31:0] prev, input int unsigned sb);
        logic [31:0] keep;
        int          r;
        keep = byte_mask(eff_bytes(sb[srle_pkg::BYTES_WIDTH-1:0]));
        r    = $urandom_range(0, 9);
        if (r < 5) return (prev & keep) | ($urandom() & ~keep);
        if (r == 5) return 32'h0;
        if (r == 6) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    task automatic send_symbol(input logic [31:0] sym, input bit last, input int n_writes,
                               input coded_write_t fin);
        int gap;
        gap = ((sent_items / 32) % 4 == 1) ? 0 : idle_len();
        sent_items++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_symbol      <= sym;
        s_last_symbol <= last;
        known_n       <= n_writes;
        known_w       <= fin;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [srle_pkg::CFG_DATA_WIDTH-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic set_config(input int unsigned sb,
                              input logic [srle_pkg::CFG_DATA_WIDTH-1:0] cap);
        wait_drained();
        write_reg(srle_pkg::CFG_SYMBOL_BYTES, srle_pkg::CFG_DATA_WIDTH'(sb));
        write_reg(srle_pkg::CFG_CAPACITY, cap);
        cfg_write <= 1'b0;
    endtask

    initial begin
        int stall;
        int cyc;
        stall = 0;
        cyc   = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if ((cyc / 200) % 4 != 2) stall = idle_len();
            end
        end
    end

    initial begin
        int unsigned phase_sb [7];
        logic [23:0] phase_cap [7];
        logic [31:0] sym;
        int          len;
        int          n_phase;
        aresetn       <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= srle_pkg::CFG_SYMBOL_BYTES;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_symbol      <= '0;
        s_last_symbol <= 1'b0;
        known_n       <= -1;
        known_w       <= '0;
        phase_sb  = '{2, 3, 4, 1, 0, 6, 1};
        phase_cap = '{24'hFF_FFFF, 24'd60, 24'hFF_FFFF, 24'd1, 24'd25, 24'hFF_FFFF, 24'd40};
        directed_rows = '{
            sym_row(32'h0000_00AB, 1'b1, 2, fin_w(0, 0, 1, 1'b1, 1'b1, 2, 1'b0)),
            sym_row(32'hFFFF_FFFF, 1'b0, 0),
            // upper bytes beyond the symbol size do not break the run
            sym_row(32'h1234_56FF, 1'b0, 1, fin_w(1, 32'hFF, 1, 1'b0, 1'b0, 0, 1'b0)),
            sym_row(32'h0000_00FF, 1'b1, 1, fin_w(0, 129, 1, 1'b1, 1'b1, 2, 1'b0)),
            sym_row(32'h0000_0000, 1'b0, 0),
            sym_row(32'h0000_0001, 1'b0),
            sym_row(32'h0000_0001, 1'b0),
            sym_row(32'h0000_0002, 1'b1, 3, fin_w(4, 0, 1, 1'b1, 1'b1, 6, 1'b0)),
            cfg_row(srle_pkg::CFG_SYMBOL_BYTES, 32'd4),
            sym_row(32'hFFFF_FFFF, 1'b0, 0),
            sym_row(32'h0000_0000, 1'b1, 3, fin_w(0, 1, 1, 1'b1, 1'b1, 9, 1'b0)),
            // capacity exceeded mid stream, then dropped symbols until the last
            cfg_row(srle_pkg::CFG_CAPACITY, 32'd6),
            sym_row(32'h0000_0005, 1'b0, 0),
            sym_row(32'h0000_0006, 1'b0, 1, fin_w(1, 5, 4, 1'b0, 1'b0, 0, 1'b0)),
            sym_row(32'h0000_0007, 1'b0, 1, fin_w(0, 0, 0, 1'b0, 1'b0, 0, 1'b1)),
            sym_row(32'h0000_0008, 1'b0, 0),
            sym_row(32'h0000_0009, 1'b1, 1, fin_w(0, 0, 0, 1'b0, 1'b1, 0, 1'b1)),
            // zero capacity
            cfg_row(srle_pkg::CFG_CAPACITY, 32'd0),
            sym_row(32'h0000_0003, 1'b1, 1, fin_w(0, 0, 0, 1'b0, 1'b1, 0, 1'b1)),
            // symbol size out of range on both sides
            cfg_row(srle_pkg::CFG_SYMBOL_BYTES, 32'd0),
            cfg_row(srle_pkg::CFG_CAPACITY, 32'hFF_FFFF),
            sym_row(32'h1234_5678, 1'b0, 0),
            sym_row(32'hAA00_0078, 1'b1, 2, fin_w(0, 128, 1, 1'b1, 1'b1, 2, 1'b0)),
            cfg_row(srle_pkg::CFG_SYMBOL_BYTES, 32'd7),
            sym_row(32'h8000_0001, 1'b0, 0),
            sym_row(32'h8000_0001, 1'b1, 2, fin_w(0, 128, 1, 1'b1, 1'b1, 5, 1'b0))
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                wait_drained();
                write_reg(directed_rows[i].reg_index,
                          directed_rows[i].value[srle_pkg::CFG_DATA_WIDTH-1:0]);
                cfg_write <= 1'b0;
            end else begin
                send_symbol(directed_rows[i].value, directed_rows[i].last,
                            directed_rows[i].n_writes, directed_rows[i].fin);
            end
        end

        foreach (phase_sb[p]) begin
            set_config(phase_sb[p], phase_cap[p]);
            n_phase = 0;
            while (n_phase < 4) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
                sym = $urandom();
                for (int i = 0; i < len; i++) begin
                    sym = next_symbol(sym, phase_sb[p]);
                    send_symbol(sym, i == len - 1, -1, '0);
                end
                n_phase += len;
            end
        end

        // one long stream: a run past the longest run packet, then a literal past the longest
        set_config(1, 24'hFF_FFFF);
        sym = $urandom_range(0, 255);
        for (int i = 0; i < 131; i++)
            send_symbol(sym | ($urandom() & 32'hFFFF_FF00), 1'b0, -1, '0);
        wait_drained();
        for (int i = 1; i <= 130; i++)
            send_symbol(((sym + i) & 32'hFF) | ($urandom() & 32'hFFFF_FF00), i == 130, -1, '0);

        s_valid <= 1'b0;
        @(posedge aclk);
        for (int i = 0; i < 5000 && pending_writes.size() != 0; i++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (pending_writes.size() != 0) begin
            $display("%0t results: expected %0d more, actual 0", $time, pending_writes.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("symbol_rle_encoder_tb: PASS");
        else
            $display("symbol_rle_encoder_tb: FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("symbol_rle_encoder_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/srle_pkg.sv
design/symbol_rle_encoder.sv
design/srle_checker.sv
dv/symbol_rle_encoder_tb.sv
